// File: hdl/dual_gradient_energy_core_assert.svh
// ----------------------------------------------------------------------------
// dual gradient energy core assertion macros
// shared concurrent assertion wrappers, compiled out with ASSERT_OFF
// ----------------------------------------------------------------------------
`ifndef DUAL_GRADIENT_ENERGY_CORE_ASSERT_SVH
`define DUAL_GRADIENT_ENERGY_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define DGE_ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define DGE_ASSERT_CLK(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DGE_ASSERT_RST(lbl, clk, rst, prop, msg)
`define DGE_ASSERT_CLK(lbl, clk, prop, msg)
`endif

`endif

// File: hdl/dge_pkg.sv
// ----------------------------------------------------------------------------
// dge_pkg
// shared constants and control types of the dual gradient energy core
// ----------------------------------------------------------------------------
package dge_pkg;

   localparam int MAX_WIDTH_DEF  = 256;
   localparam int MAX_HEIGHT_DEF = 256;

   localparam int COORD_W  = 9;
   localparam int PIX_W    = 24;
   localparam int CHAN_W   = 8;
   localparam int SUM_W    = 19;
   localparam int ROOT_W   = 10;
   localparam int ENERGY_W = 6;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;

   localparam logic [COORD_W-1:0] SIZE_RESET = 9'd256;
   localparam logic [COORD_W-1:0] SIZE_MIN   = 9'd2;

   // floor(x / 10) as (x * 205) >> 11, exact for x below 1029
   localparam logic [7:0] DIV_RECIP = 8'd205;
   localparam int         DIV_SHIFT = 11;

   localparam logic CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic CSR_IMAGE_HEIGHT = 1'b1;

   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   typedef enum logic [1:0] {
      NB_RIGHT,
      NB_LEFT,
      NB_DOWN,
      NB_UP
   } nbr_type;

   typedef struct packed {
      logic [COORD_W-1:0] width;
      logic [COORD_W-1:0] height;
   } size_type;

   typedef struct packed {
      logic       capture;
      logic       write_pixel;
      logic       read_en;
      nbr_type    read_sel;
      logic       load_pix;
      nbr_type    pix_sel;
      logic       sum_clear;
      logic       sum_en;
      logic [1:0] chan_sel;
      logic       sqrt_init;
      logic       sqrt_step;
      logic       out_load;
   } cmd_type;

endpackage

// File: hdl/dge_regs.sv
// ----------------------------------------------------------------------------
// dge_regs
// apb register file holding the image size, clamped for the datapath
// ----------------------------------------------------------------------------
module dge_regs #(
   parameter int MAX_WIDTH  = dge_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = dge_pkg::MAX_HEIGHT_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [dge_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [dge_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [dge_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                         csr_pready,
   output dge_pkg::size_type            size
);

   localparam int CSR_DW_T = dge_pkg::CSR_DW;

   logic [dge_pkg::COORD_W-1:0] width_ff, width_in;
   logic [dge_pkg::COORD_W-1:0] height_ff, height_in;
   logic                        wr_en;

   assign wr_en = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (wr_en) begin
         unique case (csr_paddr[2])
            dge_pkg::CSR_IMAGE_WIDTH:  width_in  = csr_pwdata[dge_pkg::COORD_W-1:0];
            dge_pkg::CSR_IMAGE_HEIGHT: height_in = csr_pwdata[dge_pkg::COORD_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= dge_pkg::SIZE_RESET;
         height_ff <= dge_pkg::SIZE_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         dge_pkg::CSR_IMAGE_WIDTH:  csr_prdata = CSR_DW_T'(width_ff);
         dge_pkg::CSR_IMAGE_HEIGHT: csr_prdata = CSR_DW_T'(height_ff);
         default:                   csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;

   // saturate to 2..max
   always_comb begin
      if (width_ff < dge_pkg::SIZE_MIN) begin
         size.width = dge_pkg::SIZE_MIN;
      end else if (32'(width_ff) > MAX_WIDTH) begin
         size.width = dge_pkg::COORD_W'(MAX_WIDTH);
      end else begin
         size.width = width_ff;
      end
      if (height_ff < dge_pkg::SIZE_MIN) begin
         size.height = dge_pkg::SIZE_MIN;
      end else if (32'(height_ff) > MAX_HEIGHT) begin
         size.height = dge_pkg::COORD_W'(MAX_HEIGHT);
      end else begin
         size.height = height_ff;
      end
   end

endmodule

// File: hdl/dge_ctrl.sv
// ----------------------------------------------------------------------------
// dge_ctrl
// sequencer for pixel loads and energy queries, owns both handshakes
// ----------------------------------------------------------------------------
`include "dual_gradient_energy_core_assert.svh"

module dge_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_mode,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output dge_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      IDLE,
      READ,
      SUM,
      ROOT,
      DONE
   } state_type;

   localparam logic [3:0] READ_LAST = 4'd4;
   localparam logic [3:0] SUM_LAST  = 4'd2;
   localparam logic [3:0] ROOT_LAST = 4'd10;

   state_type  state_ff, state_in;
   logic [3:0] cnt_ff, cnt_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;

   assign req_ready = (state_ff == IDLE) && !reset;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               if (req_mode == dge_pkg::MODE_LOAD) begin
                  cmd.write_pixel = 1'b1;
               end else begin
                  state_in = READ;
                  cnt_in   = '0;
               end
            end
         end
         READ: begin
            // read issued at cnt, its data is loaded into pix_ff at cnt+1
            cmd.read_en  = (cnt_ff != READ_LAST);
            cmd.read_sel = dge_pkg::nbr_type'(cnt_ff[1:0]);
            cmd.load_pix = (cnt_ff != '0);
            cmd.pix_sel  = dge_pkg::nbr_type'(2'(cnt_ff - 4'd1));
            cnt_in       = cnt_ff + 4'd1;
            if (cnt_ff == READ_LAST) begin
               cmd.sum_clear = 1'b1;
               state_in      = SUM;
               cnt_in        = '0;
            end
         end
         SUM: begin
            cmd.sum_en   = 1'b1;
            cmd.chan_sel = cnt_ff[1:0];
            cnt_in       = cnt_ff + 4'd1;
            if (cnt_ff == SUM_LAST) begin
               state_in = ROOT;
               cnt_in   = '0;
            end
         end
         ROOT: begin
            cmd.sqrt_init = (cnt_ff == '0);
            cmd.sqrt_step = (cnt_ff != '0);
            cnt_in        = cnt_ff + 4'd1;
            if (cnt_ff == ROOT_LAST) begin
               state_in = DONE;
               cnt_in   = '0;
            end
         end
         DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
      rsp_valid_in = cmd.out_load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `DGE_ASSERT_RST(a_no_overwrite, clock, reset,
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready), "result overwritten before taken")
   `DGE_ASSERT_RST(a_query_starts, clock, reset,
      (accept && req_mode == dge_pkg::MODE_QUERY) |=> (state_ff == READ && cnt_ff == '0),
      "query did not start reads")
   `DGE_ASSERT_RST(a_load_stays_idle, clock, reset,
      cmd.write_pixel |=> (state_ff == IDLE && !cmd.load_pix), "load beat left idle")
   `DGE_ASSERT_RST(a_root_to_done, clock, reset,
      (state_ff == ROOT && cnt_ff == ROOT_LAST) |=> (state_ff == DONE),
      "root iterations not ending in done")

endmodule

// File: hdl/dge_datapath.sv
// ----------------------------------------------------------------------------
// dge_datapath
// frame store, neighbor addressing, gradient sum, square root and scaling
// ----------------------------------------------------------------------------
module dge_datapath #(
   parameter int MAX_WIDTH  = dge_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = dge_pkg::MAX_HEIGHT_DEF
) (
   input  logic                            clock,
   input  dge_pkg::cmd_type                cmd,
   input  dge_pkg::size_type               size,
   input  logic [7:0]                      req_row,
   input  logic [7:0]                      req_col,
   input  logic [7:0]                      req_red,
   input  logic [7:0]                      req_green,
   input  logic [7:0]                      req_blue,
   output logic [dge_pkg::ENERGY_W-1:0]    rsp_energy,
   output logic [7:0]                      rsp_out_row,
   output logic [7:0]                      rsp_out_col
);

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = dge_pkg::COORD_W;
   localparam int SW    = dge_pkg::SUM_W;
   localparam int PW    = dge_pkg::PIX_W;
   localparam int QW    = dge_pkg::ROOT_W + 8;

   logic [PW-1:0] mem [DEPTH];

   logic [7:0]    row_ff, col_ff;
   logic [CW-1:0] cr_ff, cl_ff, rd_ff, ru_ff;
   logic [CW-1:0] row9, col9;
   logic [CW-1:0] cr_in, cl_in, rd_in, ru_in;

   logic [CW-1:0] rsel, csel;
   logic          rd_inrange;
   logic [AW-1:0] rd_addr;
   logic          wr_inrange;
   logic [AW-1:0] wr_addr;
   logic [PW-1:0] rd_data_ff;
   logic          rd_zero_ff;
   logic [PW-1:0] pix_ff [4];

   logic [7:0]    xr, xl, yd, yu, dx, dy;
   logic [SW-1:0] sum_ff;

   logic [SW-1:0] v_ff;
   logic [SW-1:0] res_ff;
   logic [SW-1:0] bit_ff;
   logic [SW:0]   trial;

   logic [QW-1:0]                 quot;
   logic [dge_pkg::ENERGY_W-1:0]  energy_ff;
   logic [7:0]                    out_row_ff, out_col_ff;

   // wrap-around neighbors
   always_comb begin
      row9  = {1'b0, req_row};
      col9  = {1'b0, req_col};
      cr_in = ((col9 + 9'd1) < size.width)  ? col9 + 9'd1 : '0;
      cl_in = (col9 != '0) ? col9 - 9'd1 : size.width - 9'd1;
      rd_in = ((row9 + 9'd1) < size.height) ? row9 + 9'd1 : '0;
      ru_in = (row9 != '0) ? row9 - 9'd1 : size.height - 9'd1;
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         row_ff <= req_row;
         col_ff <= req_col;
         cr_ff  <= cr_in;
         cl_ff  <= cl_in;
         rd_ff  <= rd_in;
         ru_ff  <= ru_in;
      end
   end

   // frame store write
   assign wr_inrange = (32'(req_row) < MAX_HEIGHT) && (32'(req_col) < MAX_WIDTH);
   assign wr_addr    = AW'(AW'(req_row) * AW'(MAX_WIDTH)) + AW'(req_col);

   always_ff @(posedge clock) begin
      if (cmd.write_pixel && wr_inrange) begin
         mem[wr_addr] <= {req_red, req_green, req_blue};
      end
   end

   // frame store read
   always_comb begin
      case (cmd.read_sel)
         dge_pkg::NB_RIGHT: begin
            rsel = {1'b0, row_ff};
            csel = cr_ff;
         end
         dge_pkg::NB_LEFT: begin
            rsel = {1'b0, row_ff};
            csel = cl_ff;
         end
         dge_pkg::NB_DOWN: begin
            rsel = rd_ff;
            csel = {1'b0, col_ff};
         end
         default: begin
            rsel = ru_ff;
            csel = {1'b0, col_ff};
         end
      endcase
   end

   assign rd_inrange = (32'(rsel) < MAX_HEIGHT) && (32'(csel) < MAX_WIDTH);
   assign rd_addr    = AW'(AW'(rsel) * AW'(MAX_WIDTH)) + AW'(csel);

   always_ff @(posedge clock) begin
      if (cmd.read_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_zero_ff <= !rd_inrange;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_pix) begin
         pix_ff[cmd.pix_sel] <= rd_zero_ff ? '0 : rd_data_ff;
      end
   end

   // one channel of both gradients per cycle
   always_comb begin
      case (cmd.chan_sel)
         2'd0: begin
            xr = pix_ff[dge_pkg::NB_RIGHT][23:16];
            xl = pix_ff[dge_pkg::NB_LEFT][23:16];
            yd = pix_ff[dge_pkg::NB_DOWN][23:16];
            yu = pix_ff[dge_pkg::NB_UP][23:16];
         end
         2'd1: begin
            xr = pix_ff[dge_pkg::NB_RIGHT][15:8];
            xl = pix_ff[dge_pkg::NB_LEFT][15:8];
            yd = pix_ff[dge_pkg::NB_DOWN][15:8];
            yu = pix_ff[dge_pkg::NB_UP][15:8];
         end
         default: begin
            xr = pix_ff[dge_pkg::NB_RIGHT][7:0];
            xl = pix_ff[dge_pkg::NB_LEFT][7:0];
            yd = pix_ff[dge_pkg::NB_DOWN][7:0];
            yu = pix_ff[dge_pkg::NB_UP][7:0];
         end
      endcase
      dx = (xr > xl) ? xr - xl : xl - xr;
      dy = (yd > yu) ? yd - yu : yu - yd;
   end

   always_ff @(posedge clock) begin
      if (cmd.sum_clear) begin
         sum_ff <= '0;
      end else if (cmd.sum_en) begin
         sum_ff <= sum_ff + SW'(16'(dx * dx)) + SW'(16'(dy * dy));
      end
   end

   // digit-by-digit integer square root, two bits per step
   assign trial = {1'b0, res_ff} + {1'b0, bit_ff};

   always_ff @(posedge clock) begin
      if (cmd.sqrt_init) begin
         v_ff   <= sum_ff;
         res_ff <= '0;
         bit_ff <= SW'(1) << (SW - 1);
      end else if (cmd.sqrt_step) begin
         if ({1'b0, v_ff} >= trial) begin
            v_ff   <= v_ff - trial[SW-1:0];
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   // divide by ten through the reciprocal
   assign quot = res_ff[dge_pkg::ROOT_W-1:0] * dge_pkg::DIV_RECIP;

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         energy_ff  <= quot[dge_pkg::DIV_SHIFT +: dge_pkg::ENERGY_W];
         out_row_ff <= row_ff;
         out_col_ff <= col_ff;
      end
   end

   assign rsp_energy  = energy_ff;
   assign rsp_out_row = out_row_ff;
   assign rsp_out_col = out_col_ff;

endmodule

// File: hdl/dual_gradient_energy_core.sv
// ----------------------------------------------------------------------------
// dual_gradient_energy_core
// frame store with dual-gradient energy queries for seam carving
// ----------------------------------------------------------------------------
//  channel   ports    direction   beat
//  request   req_*    in          one pixel load or one energy query
//  response  rsp_*    out         energy, row and column of one query
//  csr       csr_*    in/out      apb access to image width and height
//
//  a load is written in the cycle it is accepted
//  a query runs four reads through the single frame store port,
//  three gradient sum steps and ten square root iterations, then the result
//  the finished result sits in an output register, so loads keep flowing
//  while it waits; a query waits in its last step until that register frees
//  synchronous reset clears control and size registers, the store is not
//  cleared and needs no clearing pass
// ----------------------------------------------------------------------------
module dual_gradient_energy_core #(
   parameter int MAX_WIDTH  = dge_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = dge_pkg::MAX_HEIGHT_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_mode,
   input  logic [7:0]                    req_row,
   input  logic [7:0]                    req_col,
   input  logic [7:0]                    req_red,
   input  logic [7:0]                    req_green,
   input  logic [7:0]                    req_blue,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [dge_pkg::ENERGY_W-1:0]  rsp_energy,
   output logic [7:0]                    rsp_out_row,
   output logic [7:0]                    rsp_out_col,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [dge_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [dge_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [dge_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                          csr_pready
);

   dge_pkg::cmd_type  cmd;
   dge_pkg::size_type size;

   dge_regs #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_regs (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .size        (size)
   );

   dge_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   dge_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_datapath (
      .clock       (clock),
      .cmd         (cmd),
      .size        (size),
      .req_row     (req_row),
      .req_col     (req_col),
      .req_red     (req_red),
      .req_green   (req_green),
      .req_blue    (req_blue),
      .rsp_energy  (rsp_energy),
      .rsp_out_row (rsp_out_row),
      .rsp_out_col (rsp_out_col)
   );

endmodule
